FILE: rtl/wav_header_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// WAV header stream parser: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_STREAM_PARSER_DEFINES_SVH
`define WAV_HEADER_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication.
`define WHSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WHSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/whsp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header stream parser package
// Transfer types, parse phase codes, field codes and header field lengths.
// ----------------------------------------------------------------------------
package whsp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_code;
    logic [31:0] field_value;
    logic        is_last;
  } out_item_t;

  // Input register toward the parser.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Parser result toward the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // Parse phases; phases 0 through PH_HDR_LAST are the fixed header fields.
  localparam logic [4:0] PH_RIFF_ID  = 5'd0;
  localparam logic [4:0] PH_HDR_LAST = 5'd10;
  localparam logic [4:0] PH_CHUNKID  = 5'd11;
  localparam logic [4:0] PH_LISTSIZE = 5'd12;
  localparam logic [4:0] PH_INFO     = 5'd13;
  localparam logic [4:0] PH_TAG      = 5'd14;
  localparam logic [4:0] PH_NODELEN  = 5'd15;
  localparam logic [4:0] PH_NODEBYTE = 5'd16;
  localparam logic [4:0] PH_PAD      = 5'd17;
  localparam logic [4:0] PH_DATAID   = 5'd18;
  localparam logic [4:0] PH_DATASIZE = 5'd19;
  localparam logic [4:0] PH_PAYLOAD  = 5'd20;
  localparam logic [4:0] PH_DONE     = 5'd21;

  // Two-byte header fields (header codes equal their phase).
  localparam logic [4:0] FC_FORMAT   = 5'd5;
  localparam logic [4:0] FC_CHANNELS = 5'd6;
  localparam logic [4:0] FC_ALIGN    = 5'd9;
  localparam logic [4:0] FC_BITS     = 5'd10;

  // Field codes beyond the header fields (header codes equal their phase).
  localparam logic [4:0] FC_INFO_TYPE = 5'd11;
  localparam logic [4:0] FC_NODE_TAG  = 5'd12;
  localparam logic [4:0] FC_NODE_LEN  = 5'd13;
  localparam logic [4:0] FC_NODE_BYTE = 5'd14;
  localparam logic [4:0] FC_DATA_SIZE = 5'd15;
  localparam logic [4:0] FC_DATA_BYTE = 5'd16;
  localparam logic [4:0] FC_CHUNK_ID  = 5'd17;

  localparam logic [31:0] ID_LIST       = 32'h5453_494C;
  localparam logic [31:0] LIST_TYPE_LEN = 32'd4;
  localparam logic [33:0] NODE_HDR_LEN  = 34'd8;

  // Byte count of each header field.
  function automatic logic [2:0] hdr_len(input logic [4:0] ph);
    logic [2:0] len;
    case (ph)
      FC_FORMAT, FC_CHANNELS, FC_ALIGN, FC_BITS: len = 3'd2;
      default:                                   len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/whsp_in_stage.sv
// ----------------------------------------------------------------------------
// WAV header stream parser: input register
// Holds one incoming byte until the parser consumes it.
// ----------------------------------------------------------------------------
module whsp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  whsp_pkg::in_item_t in_data,
  input  logic               consume,
  output whsp_pkg::stage_t   stg
);
  import whsp_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     load;

  // Refill whenever the held byte is empty or leaves this cycle.
  assign load     = !valid_r || consume;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_data;
    end
  end

  assign stg.valid = valid_r;
  assign stg.item  = item_r;

endmodule

FILE: rtl/whsp_parser.sv
// ----------------------------------------------------------------------------
// WAV header stream parser: field parser
// Phase register, little-endian field assembly and the list, node and data
// byte counters; one byte is handled per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "wav_header_stream_parser_defines.svh"

module whsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  whsp_pkg::stage_t  stg,
  input  logic              out_ready,
  output logic              consume,
  output whsp_pkg::result_t res
);
  import whsp_pkg::*;

  logic [4:0]  phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] list_r, list_nxt;
  logic [31:0] node_r, node_nxt;
  logic [31:0] data_r, data_nxt;

  logic        sof;
  logic [7:0]  b;
  logic [4:0]  cur_phase, eff_phase;
  logic [1:0]  cur_bif;
  logic [31:0] cur_shift, cur_list, cur_node, cur_data;
  logic [31:0] acc;
  logic [2:0]  need_len;
  logic        fdone;
  logic        pad_skip;
  logic        is_take;
  logic [33:0] node_cost;
  logic [31:0] node_dec, data_dec;
  logic        emit;
  logic [4:0]  code;
  logic [31:0] value;
  logic        last;

  assign consume = stg.valid && out_ready;
  assign sof     = stg.item.start_of_file;
  assign b       = stg.item.in_byte;

  always_comb begin
    // Start of file restarts from a clean state with this byte.
    cur_phase = sof ? PH_RIFF_ID : phase_r;
    cur_bif   = sof ? 2'd0 : bif_r;
    cur_shift = sof ? '0 : shift_r;
    cur_list  = sof ? '0 : list_r;
    cur_node  = sof ? '0 : node_r;
    cur_data  = sof ? '0 : data_r;

    phase_nxt = cur_phase;
    bif_nxt   = cur_bif;
    shift_nxt = cur_shift;
    list_nxt  = cur_list;
    node_nxt  = cur_node;
    data_nxt  = cur_data;
    emit      = 1'b0;
    code      = cur_phase;
    last      = 1'b0;
    pad_skip  = 1'b0;
    eff_phase = cur_phase;

    // Zero padding eats list bytes; the first nonzero byte opens a tag or id.
    if (cur_phase == PH_PAD) begin
      if (b == 8'd0) begin
        pad_skip = 1'b1;
        list_nxt = (cur_list == '0) ? '0 : cur_list - 32'd1;
      end else begin
        eff_phase = (cur_list != '0) ? PH_TAG : PH_DATAID;
        phase_nxt = eff_phase;
      end
    end

    need_len  = (eff_phase <= PH_HDR_LAST) ? hdr_len(eff_phase) : 3'd4;
    acc       = cur_shift | ({24'd0, b} << {cur_bif, 3'b000});
    value     = acc;
    fdone     = ({1'b0, cur_bif} + 3'd1) >= need_len;
    is_take   = !pad_skip && (eff_phase <= PH_DATASIZE) &&
                (eff_phase != PH_NODEBYTE) && (eff_phase != PH_PAD);
    node_cost = {2'b00, acc} + NODE_HDR_LEN;
    node_dec  = cur_node - 32'd1;
    data_dec  = cur_data - 32'd1;

    if (is_take) begin
      if (fdone) begin
        shift_nxt = '0;
        bif_nxt   = 2'd0;
      end else begin
        shift_nxt = acc;
        bif_nxt   = cur_bif + 2'd1;
      end
    end

    if (!pad_skip) begin
      case (eff_phase)
        PH_CHUNKID: begin
          if (fdone) begin
            phase_nxt = (acc == ID_LIST) ? PH_LISTSIZE : PH_DATASIZE;
            emit      = 1'b1;
            code      = FC_CHUNK_ID;
          end
        end
        PH_LISTSIZE: begin
          if (fdone) begin
            list_nxt  = (acc >= LIST_TYPE_LEN) ? acc - LIST_TYPE_LEN : '0;
            phase_nxt = PH_INFO;
          end
        end
        PH_INFO: begin
          if (fdone) begin
            phase_nxt = (cur_list != '0) ? PH_TAG : PH_DATAID;
            emit      = 1'b1;
            code      = FC_INFO_TYPE;
          end
        end
        PH_TAG: begin
          if (fdone) begin
            phase_nxt = PH_NODELEN;
            emit      = 1'b1;
            code      = FC_NODE_TAG;
          end
        end
        PH_NODELEN: begin
          if (fdone) begin
            node_nxt  = acc;
            // Clamp the list count at zero on overrun.
            list_nxt  = ({2'b00, cur_list} >= node_cost) ?
                        cur_list - node_cost[31:0] : '0;
            phase_nxt = (acc != '0) ? PH_NODEBYTE : PH_PAD;
            emit      = 1'b1;
            code      = FC_NODE_LEN;
          end
        end
        PH_NODEBYTE: begin
          node_nxt  = node_dec;
          phase_nxt = (node_dec == '0) ? PH_PAD : PH_NODEBYTE;
          emit      = 1'b1;
          code      = FC_NODE_BYTE;
          value     = {24'd0, b};
        end
        PH_DATAID: begin
          if (fdone) begin
            phase_nxt = PH_DATASIZE;
            emit      = 1'b1;
            code      = FC_CHUNK_ID;
          end
        end
        PH_DATASIZE: begin
          if (fdone) begin
            data_nxt  = acc;
            phase_nxt = (acc != '0) ? PH_PAYLOAD : PH_DONE;
            emit      = 1'b1;
            code      = FC_DATA_SIZE;
          end
        end
        PH_PAYLOAD: begin
          data_nxt  = data_dec;
          phase_nxt = (data_dec == '0) ? PH_DONE : PH_PAYLOAD;
          last      = (data_dec == '0);
          emit      = 1'b1;
          code      = FC_DATA_BYTE;
          value     = {24'd0, b};
        end
        default: begin
          // Fixed header fields advance one phase each; anything else parks.
          if (eff_phase <= PH_HDR_LAST) begin
            if (fdone) begin
              phase_nxt = eff_phase + 5'd1;
              emit      = 1'b1;
              code      = eff_phase;
            end
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF_ID;
      bif_r   <= 2'd0;
      shift_r <= '0;
      list_r  <= '0;
      node_r  <= '0;
      data_r  <= '0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      shift_r <= shift_nxt;
      list_r  <= list_nxt;
      node_r  <= node_nxt;
      data_r  <= data_nxt;
    end
  end

  assign res.valid            = consume && emit;
  assign res.item.field_code  = code;
  assign res.item.field_value = value;
  assign res.item.is_last     = last;

  `WHSP_ASSERT_IMP(a_node_count_live, phase_r == PH_NODEBYTE, node_r != '0, "node count empty")
  `WHSP_ASSERT_IMP(a_data_count_live, phase_r == PH_PAYLOAD, data_r != '0, "data count empty")
  `WHSP_ASSERT_NXT(a_last_parks, res.valid && res.item.is_last, phase_r == PH_DONE, "not parked")

endmodule

FILE: rtl/whsp_out_stage.sv
// ----------------------------------------------------------------------------
// WAV header stream parser: output register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`include "wav_header_stream_parser_defines.svh"

module whsp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  whsp_pkg::result_t   res,
  output logic                out_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output whsp_pkg::out_item_t out_data
);
  import whsp_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign out_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res.valid) begin
      item_r <= res.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = item_r;

  `WHSP_ASSERT_IMP(a_last_on_payload, valid_r && item_r.is_last,
                   item_r.field_code == FC_DATA_BYTE, "last flag off payload")

endmodule

FILE: rtl/wav_header_stream_parser.sv
// ----------------------------------------------------------------------------
// WAV header stream parser
// Byte-serial RIFF/WAVE header walker with LIST walking and payload output.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while out_stall does not hold the output and
// reports each completed header field, the chunk ids, the LIST info type and
// nodes, the data size and every payload byte (the last flagged), at most one
// result per byte. A byte is registered on its input transfer, parsed by the
// combinational phase and counter update once the output register can take
// a result, and its result is then registered in the output register; a new
// byte can enter while the last is parsed. start_of_file restarts the parse.
module wav_header_stream_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  whsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output whsp_pkg::out_item_t out_data
);
  import whsp_pkg::*;

  stage_t  stg;
  result_t res;
  logic    consume;
  logic    out_ready;

  whsp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .consume  (consume),
    .stg      (stg)
  );

  whsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg       (stg),
    .out_ready (out_ready),
    .consume   (consume),
    .res       (res)
  );

  whsp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
